// File: src/utbs_pkg.sv
package utbs_pkg;

    // Data format: signed Q16.16
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = DATA_W - FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;

    // System size; the index ports are IDX_W bits wide
    localparam int MAX_N     = 16;
    localparam int IDX_W     = $clog2(MAX_N);
    localparam int CNT_W     = $clog2(MAX_N + 1);
    localparam int MAT_AW    = 2 * IDX_W;
    localparam int MAT_DEPTH = MAX_N * MAX_N;

    // Accumulator: shifted product plus growth over MAX_N terms and a sign
    localparam int ACC_W     = PROD_W - FRAC_BITS + CNT_W;

    // Divider step counter
    localparam int DCNT_W    = $clog2(DATA_W);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Input item actions
    typedef enum logic [1:0] {
        ACT_MAT   = 2'd0,
        ACT_RHS   = 2'd1,
        ACT_SOLVE = 2'd2
    } action_t;

    // Divider result toward the sequencer
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] quot;
    } div_res_t;

endpackage

// File: src/utbs_div.sv
module utbs_div
    import utbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  num,
    input  logic signed [DATA_W-1:0] den,
    output div_res_t                 res
);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CHECK = 4'b0010,
        D_RUN   = 4'b0100,
        D_DONE  = 4'b1000
    } dstate_t;

    dstate_t               state_reg, state_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  big_reg, big_next;
    logic [ACC_W-1:0]      num_mag_reg, num_mag_next;
    logic [DATA_W-1:0]     den_mag_reg, den_mag_next;
    logic [DATA_W-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]     quo_reg, quo_next;

    logic [DATA_W:0]       rem_shift;
    logic                  rem_ge;
    logic [DATA_W-1:0]     quo_neg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        big_reg     <= big_next;
        num_mag_reg <= num_mag_next;
        den_mag_reg <= den_mag_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_mag_reg};
    assign quo_neg   = DATA_W'(0) - quo_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        big_next     = big_reg;
        num_mag_next = num_mag_reg;
        den_mag_next = den_mag_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next     = num[ACC_W-1] ^ den[DATA_W-1];
                    num_mag_next = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
                    den_mag_next = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
                    state_next   = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // Integer part too large: saturate without iterating
                big_next = num_mag_reg >= ACC_W'({den_mag_reg, {INT_BITS{1'b0}}});
                rem_next = DATA_W'(num_mag_reg >> INT_BITS);
                quo_next = {num_mag_reg[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
                cnt_next = '0;
                state_next = big_next ? D_DONE : D_RUN;
            end
            D_RUN:
            begin
                rem_next = rem_ge ? DATA_W'(rem_shift - {1'b0, den_mag_reg})
                                  : rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DATA_W - 1))
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Sign and saturation of the magnitude quotient
    always_comb
    begin
        res.done = (state_reg == D_DONE);
        if (neg_reg)
        begin
            res.sat  = big_reg || (quo_reg > SAT_MIN);
            res.quot = res.sat ? SAT_MIN : quo_neg;
        end
        else
        begin
            res.sat  = big_reg || quo_reg[DATA_W-1];
            res.quot = res.sat ? SAT_MAX : quo_reg;
        end
    end

endmodule

// File: src/upper_triangular_back_substitution.sv
// Upper triangular solver, A x = b, signed Q16.16. Load items (start with
// action 0 or 1) write one entry of A or b. A solve item (action 2) works
// through rows n-1 down to 0: one matrix read per multiply-accumulate step
// through the single matrix memory port, then a one-bit-per-cycle divider
// per row unless the diagonal is zero, while busy stays high. The n results
// then leave one per cycle, index 0 first, each marked by a one-cycle
// result_strobe; there is no way to hold them off, so the receiver must take
// every strobe. last marks entry n-1, and singular/overflow carry the totals
// of the whole run. The user must write size_in_use through size_in_use_wr
// only while busy is low and no result is still due; the block does not
// enforce it. 0 counts as 1 and values above 16 count as 16.
module upper_triangular_back_substitution
    import utbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     size_in_use_wr,
    input  logic [CNT_W-1:0]         size_in_use,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               action,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    output logic                     result_strobe,
    output logic [IDX_W-1:0]         index,
    output logic signed [DATA_W-1:0] solution,
    output logic                     singular,
    output logic                     overflow,
    output logic                     last
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROW   = 7'b0000010,
        S_DOT   = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_DIVW  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         size_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic                     hd_v_reg, hd_v_next;
    logic                     rd_v_reg, rd_v_next;
    logic                     mul_v_reg;
    logic                     sing_reg, sing_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_v_reg, out_v_next;
    logic [IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_sing_reg, out_sing_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_W-1:0] diag_reg, diag_next;
    logic signed [PROD_W-1:0] prod_reg;

    // Memories and their read data registers
    logic signed [DATA_W-1:0] mat_mem [MAT_DEPTH];
    logic signed [DATA_W-1:0] rhs_mem [MAX_N];
    logic signed [DATA_W-1:0] sol_mem [MAX_N];
    logic signed [DATA_W-1:0] mat_rdata_reg;
    logic signed [DATA_W-1:0] rhs_rdata_reg;
    logic signed [DATA_W-1:0] sol_rdata_reg;

    logic                     accept;
    logic                     mat_we, rhs_we, sol_we;
    logic [MAT_AW-1:0]        mat_raddr;
    logic [IDX_W-1:0]         sol_raddr;
    logic signed [DATA_W-1:0] sol_wdata;
    logic [CNT_W-1:0]         n_eff;
    logic                     div_start;
    div_res_t                 div_res;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign mat_we = accept && (action == ACT_MAT);
    assign rhs_we = accept && (action == ACT_RHS);

    // Effective size: zero counts as one, clamp to MAX_N
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (size_reg > CNT_W'(MAX_N))
        begin
            n_eff = CNT_W'(MAX_N);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    // Matrix memory: loads write, solve reads
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[{row, col}] <= value;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    // Right-hand side memory
    always_ff @(posedge clk)
    begin
        if (rhs_we)
        begin
            rhs_mem[row] <= value;
        end
        rhs_rdata_reg <= rhs_mem[i_reg];
    end

    // Solution memory: a row writes x[i] only after all its reads of x[j > i]
    always_ff @(posedge clk)
    begin
        if (sol_we)
        begin
            sol_mem[i_reg] <= sol_wdata;
        end
        sol_rdata_reg <= sol_mem[sol_raddr];
    end

    // Product stage, plus accumulator and diagonal registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mat_rdata_reg) * PROD_W'(sol_rdata_reg);
        acc_reg  <= acc_next;
        diag_reg <= diag_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            size_reg     <= CNT_W'(MAX_N);
            n_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            hd_v_reg     <= 1'b0;
            rd_v_reg     <= 1'b0;
            mul_v_reg    <= 1'b0;
            sing_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            out_v_reg    <= 1'b0;
            out_idx_reg  <= '0;
            out_last_reg <= 1'b0;
            out_sing_reg <= 1'b0;
            out_ovf_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (size_in_use_wr)
            begin
                size_reg <= size_in_use;
            end
            n_reg        <= n_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            hd_v_reg     <= hd_v_next;
            rd_v_reg     <= rd_v_next;
            mul_v_reg    <= rd_v_reg;
            sing_reg     <= sing_next;
            ovf_reg      <= ovf_next;
            out_v_reg    <= out_v_next;
            out_idx_reg  <= out_idx_next;
            out_last_reg <= out_last_next;
            out_sing_reg <= out_sing_next;
            out_ovf_reg  <= out_ovf_next;
        end
    end

    // Accumulator: load b[i] with the diagonal, then subtract floored products
    always_comb
    begin
        acc_next  = acc_reg;
        diag_next = diag_reg;
        if (hd_v_reg)
        begin
            acc_next  = ACC_W'(rhs_rdata_reg);
            diag_next = mat_rdata_reg;
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg - ACC_W'(prod_reg >>> FRAC_BITS);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        hd_v_next     = 1'b0;
        rd_v_next     = 1'b0;
        sing_next     = sing_reg;
        ovf_next      = ovf_reg;
        out_v_next    = 1'b0;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;
        out_sing_next = out_sing_reg;
        out_ovf_next  = out_ovf_reg;
        mat_raddr     = {i_reg, i_reg};
        sol_raddr     = j_reg[IDX_W-1:0];
        sol_we        = 1'b0;
        sol_wdata     = '0;
        div_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (action == ACT_SOLVE))
                begin
                    n_next     = n_eff;
                    i_next     = IDX_W'(n_eff - 1'b1);
                    sing_next  = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                // Diagonal and b[i] read here
                hd_v_next  = 1'b1;
                j_next     = CNT_W'(i_reg) + 1'b1;
                state_next = S_DOT;
            end
            S_DOT:
            begin
                mat_raddr = {i_reg, j_reg[IDX_W-1:0]};
                if (j_reg < n_reg)
                begin
                    rd_v_next = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!hd_v_reg && !rd_v_reg && !mul_v_reg)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (diag_reg == '0)
                begin
                    sol_we    = 1'b1;
                    sing_next = 1'b1;
                    if (i_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_res.done)
                begin
                    sol_we    = 1'b1;
                    sol_wdata = div_res.quot;
                    ovf_next  = ovf_reg | div_res.sat;
                    if (i_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg - 1'b1;
                        state_next = S_ROW;
                    end
                end
            end
            S_OUT:
            begin
                // Read x[k]; the transfer goes out the next cycle
                sol_raddr     = k_reg[IDX_W-1:0];
                out_v_next    = 1'b1;
                out_idx_next  = k_reg[IDX_W-1:0];
                out_last_next = (k_reg == n_reg - 1'b1);
                out_sing_next = sing_reg;
                out_ovf_next  = ovf_reg;
                k_next        = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    utbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (diag_reg),
        .res   (div_res)
    );

    // Result port
    assign result_strobe = out_v_reg;
    assign index         = out_idx_reg;
    assign solution      = sol_rdata_reg;
    assign singular      = out_sing_reg;
    assign overflow      = out_ovf_reg;
    assign last          = out_last_reg;

    // Multiply pipeline is empty whenever a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!hd_v_reg && !rd_v_reg && !mul_v_reg))
        else $error("multiply pipeline busy while idle");

    // Divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIVW))
        else $error("divider finished outside the wait state");

    // Results run in index order without gaps until the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |=>
            (result_strobe && (index == IDX_W'($past(index) + 1'b1))))
        else $error("result sequence broken");

    // Nothing follows the last result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result after last");

endmodule
